// ----- src/irrigation_pump_controller_assert.svh -----
`ifndef IRRIGATION_PUMP_CONTROLLER_ASSERT_SVH
`define IRRIGATION_PUMP_CONTROLLER_ASSERT_SVH

// check a property at every clock edge outside reset
`define IPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that the consequent holds in the cycle after the antecedent
`define IPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ipc_pkg.sv -----
`timescale 1ns / 1ps

package ipc_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int REG_IDX_W = 3;
    localparam int COUNT_W = 17;
    localparam int MINUTE_W = 11;

    localparam logic [REG_IDX_W-1:0] REG_SETPOINT    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MODE        = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OFF_DELAY   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_START_ONE   = 3'd3;

    localparam logic [9:0] LEVEL_LOW  = 10'd10;
    localparam logic [9:0] LEVEL_HIGH = 10'd500;
    localparam logic [10:0] RAW_FULL  = 11'd1023;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic       half_tick;
        logic [4:0] clock_hour;
        logic [5:0] clock_minute;
        logic [5:0] clock_second;
        logic [9:0] moisture_raw;
        logic [9:0] tank_high_raw;
        logic [9:0] tank_low_raw;
    } sample_t;

    typedef struct packed {
        logic       pump_drive;
        logic       fill_drive;
        logic       dry_lamp;
        logic [6:0] moisture_percent;
    } result_t;

    typedef struct packed {
        logic [6:0]  moisture_setpoint;
        logic        moisture_mode;
        logic [14:0] off_delay_seconds;
    } cfg_t;

endpackage

// ----- src/ipc_cfg.sv -----
`timescale 1ns / 1ps

module ipc_cfg #(
    parameter int NUM_PROGRAMS = 3
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [ipc_pkg::ADDR_W-1:0]                paddr,
    input  logic [ipc_pkg::DATA_W-1:0]                pwdata,
    output logic [ipc_pkg::DATA_W-1:0]                prdata,
    output logic                                      pready,
    output ipc_pkg::cfg_t                             cfg,
    output logic [NUM_PROGRAMS-1:0][ipc_pkg::MINUTE_W-1:0] start_minutes
);

    logic [ipc_pkg::REG_IDX_W-1:0] idx;
    logic                          wr_en;
    ipc_pkg::cfg_t                 cfg_reg;
    logic [NUM_PROGRAMS-1:0][ipc_pkg::MINUTE_W-1:0] start_reg;

    assign idx    = paddr[ipc_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;
    assign start_minutes = start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                ipc_pkg::REG_SETPOINT:  cfg_reg.moisture_setpoint <= pwdata[6:0];
                ipc_pkg::REG_MODE:      cfg_reg.moisture_mode <= pwdata[0];
                ipc_pkg::REG_OFF_DELAY: cfg_reg.off_delay_seconds <= pwdata[14:0];
                default:                cfg_reg <= cfg_reg;
            endcase
        end
    end

    for (genvar k = 0; k < NUM_PROGRAMS; k++)
    begin : g_start
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                start_reg[k] <= '0;
            end
            else if (wr_en && idx == ipc_pkg::REG_START_ONE + ipc_pkg::REG_IDX_W'(k))
            begin
                start_reg[k] <= pwdata[ipc_pkg::MINUTE_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            ipc_pkg::REG_SETPOINT:  prdata = {25'b0, cfg_reg.moisture_setpoint};
            ipc_pkg::REG_MODE:      prdata = {31'b0, cfg_reg.moisture_mode};
            ipc_pkg::REG_OFF_DELAY: prdata = {17'b0, cfg_reg.off_delay_seconds};
            default:                prdata = '0;
        endcase
        for (int k = 0; k < NUM_PROGRAMS; k++)
        begin
            if (idx == ipc_pkg::REG_START_ONE + ipc_pkg::REG_IDX_W'(k))
            begin
                prdata = {21'b0, start_reg[k]};
            end
        end
    end

endmodule

// ----- src/irrigation_pump_controller.sv -----
`timescale 1ns / 1ps
// A request is registered in sample_reg at acceptance and its result is registered
// in result_reg once the result register is free or being read out.
// Throughput: one request per cycle; the input and result registers form a
// two-stage queue, and only result_ready held low stalls the input.
// Reset (rst_n low, asynchronous): pump/fill off; counter, flags, settings zero.
module irrigation_pump_controller #(
    parameter int NUM_PROGRAMS = 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_ready,
    input  ipc_pkg::sample_t               sample,
    output logic                           result_valid,
    input  logic                           result_ready,
    output ipc_pkg::result_t               result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ipc_pkg::ADDR_W-1:0]     paddr,
    input  logic [ipc_pkg::DATA_W-1:0]     pwdata,
    output logic [ipc_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    ipc_pkg::cfg_t cfg;
    logic [NUM_PROGRAMS-1:0][ipc_pkg::MINUTE_W-1:0] start_minutes;

    ipc_pkg::sample_t sample_reg;
    logic             sample_full_reg;
    ipc_pkg::result_t result_reg;
    ipc_pkg::result_t result_next;
    logic             result_valid_reg;
    logic             pump_reg;
    logic             pump_next;
    logic             fill_reg;
    logic             fill_next;
    logic [ipc_pkg::COUNT_W-1:0] count_reg;
    logic [ipc_pkg::COUNT_W-1:0] count_next;

    logic        process;
    logic [16:0] scaled;
    logic [6:0]  pct_floor;
    logic [10:0] pct_rem;
    logic [6:0]  pct;
    logic        dry;
    logic        wet;
    logic [ipc_pkg::COUNT_W-1:0] count_tick;
    logic        delay_hit;
    logic [ipc_pkg::MINUTE_W-1:0] day_minute;
    logic        at_second_zero;
    logic        program_hit;
    logic        midnight;
    logic        pump_sched;

    ipc_cfg #(
        .NUM_PROGRAMS(NUM_PROGRAMS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .cfg          (cfg),
        .start_minutes(start_minutes)
    );

    assign process      = sample_full_reg && (!result_valid_reg || result_ready);
    assign sample_ready = !sample_full_reg || process;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // percent = raw*100/1023: divide by 1024, then correct once
    assign scaled    = {sample_reg.moisture_raw, 6'b0} + {1'b0, sample_reg.moisture_raw, 5'b0}
                     + {5'b0, sample_reg.moisture_raw, 2'b0};
    assign pct_floor = scaled[16:10];
    assign pct_rem   = {1'b0, scaled[9:0]} + {4'b0, pct_floor};
    assign pct       = pct_floor + {6'b0, pct_rem >= ipc_pkg::RAW_FULL};

    assign dry = pct < cfg.moisture_setpoint;
    assign wet = cfg.moisture_mode ? (pct > cfg.moisture_setpoint)
                                   : (pct >= cfg.moisture_setpoint);

    assign count_tick = (sample_reg.half_tick && pump_reg && wet && count_reg != ipc_pkg::COUNT_MAX)
                      ? count_reg + 1'b1 : count_reg;
    assign delay_hit  = count_tick[ipc_pkg::COUNT_W-1:1] >= {1'b0, cfg.off_delay_seconds};

    assign day_minute = {sample_reg.clock_hour, 6'b0} - {4'b0, sample_reg.clock_hour, 2'b0}
                      + {5'b0, sample_reg.clock_minute};
    assign at_second_zero = sample_reg.clock_second == 6'd0;
    assign midnight = sample_reg.clock_hour == 5'd0 && sample_reg.clock_minute == 6'd0
                   && at_second_zero;

    always_comb
    begin
        program_hit = 1'b0;
        for (int k = 0; k < NUM_PROGRAMS; k++)
        begin
            if (day_minute == start_minutes[k])
            begin
                program_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        pump_sched = pump_reg;
        if (program_hit && sample_reg.clock_minute < 6'd60 && at_second_zero && dry)
        begin
            pump_sched = 1'b1;
        end
        if (cfg.moisture_mode && dry)
        begin
            pump_sched = 1'b1;
        end
        else if (cfg.moisture_mode && delay_hit)
        begin
            pump_sched = 1'b0;
        end
        if (midnight)
        begin
            pump_sched = 1'b0;
        end

        fill_next = fill_reg;
        if (sample_reg.tank_high_raw < ipc_pkg::LEVEL_LOW)
        begin
            fill_next = 1'b0;
        end
        if (sample_reg.tank_low_raw < ipc_pkg::LEVEL_LOW
            && sample_reg.tank_high_raw > ipc_pkg::LEVEL_HIGH)
        begin
            fill_next = 1'b1;
        end

        pump_next  = pump_sched;
        count_next = count_tick;
        if (pump_sched && delay_hit)
        begin
            pump_next  = 1'b0;
            count_next = '0;
        end

        result_next.pump_drive       = pump_next;
        result_next.fill_drive       = fill_next;
        result_next.dry_lamp         = dry;
        result_next.moisture_percent = pct;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_full_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            pump_reg         <= 1'b0;
            fill_reg         <= 1'b0;
            count_reg        <= '0;
        end
        else
        begin
            if (sample_valid && sample_ready)
            begin
                sample_full_reg <= 1'b1;
            end
            else if (process)
            begin
                sample_full_reg <= 1'b0;
            end

            if (process)
            begin
                result_valid_reg <= 1'b1;
                pump_reg         <= pump_next;
                fill_reg         <= fill_next;
                count_reg        <= count_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            sample_reg <= sample;
        end
        if (process)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ----- src/ipc_checker.sv -----
`timescale 1ns / 1ps
`include "irrigation_pump_controller_assert.svh"

module ipc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       sample_valid,
    input logic                       sample_ready,
    input logic                       result_valid,
    input logic                       result_ready,
    input ipc_pkg::result_t           result,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [ipc_pkg::ADDR_W-1:0] paddr,
    input logic [ipc_pkg::DATA_W-1:0] pwdata,
    input logic [ipc_pkg::DATA_W-1:0] prdata,
    input logic                       pready
);

    `IPC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "stalled result changed")
    `IPC_ASSERT(a_percent_range, !result_valid || result.moisture_percent <= 7'd100, "moisture percent above 100")
    `IPC_ASSERT_NEXT(a_input_backpressure, result_valid && !result_ready && sample_valid && sample_ready, !sample_ready || result_ready, "request taken with both stages full")
    `IPC_ASSERT_NEXT(a_setpoint_readback, psel && penable && pwrite && pready && paddr[4:2] == ipc_pkg::REG_SETPOINT, paddr[4:2] != ipc_pkg::REG_SETPOINT || prdata[6:0] == $past(pwdata[6:0]), "setpoint readback mismatch")

endmodule

bind irrigation_pump_controller ipc_checker u_ipc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int PROGRAMS = 3;
    localparam int PASSES_PER_SETTING = 170;
    localparam int SETTINGS_COUNT = 6;

    localparam logic [ipc_pkg::REG_IDX_W-1:0] REG_START_TWO   = 3'd4;
    localparam logic [ipc_pkg::REG_IDX_W-1:0] REG_START_THREE = 3'd5;
    localparam logic [ipc_pkg::REG_IDX_W-1:0] REG_SPARE_SIX   = 3'd6;
    localparam logic [ipc_pkg::REG_IDX_W-1:0] REG_SPARE_SEVEN = 3'd7;

    typedef struct packed {
        logic                          is_write;
        logic [ipc_pkg::REG_IDX_W-1:0] reg_idx;
        logic [ipc_pkg::DATA_W-1:0]    reg_value;
        ipc_pkg::sample_t              item;
        logic                          typed;
        ipc_pkg::result_t              outcome;
    } step_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         sample_valid = 1'b0;
    logic                         sample_ready;
    ipc_pkg::sample_t             sample_bus = '0;
    logic                         result_valid;
    logic                         result_ready = 1'b0;
    ipc_pkg::result_t             result_bus;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [ipc_pkg::ADDR_W-1:0]   paddr = '0;
    logic [ipc_pkg::DATA_W-1:0]   pwdata = '0;
    logic [ipc_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    logic [6:0]                   cfg_setpoint = '0;
    logic                         cfg_mode = 1'b0;
    logic [14:0]                  cfg_off_delay = '0;
    logic [ipc_pkg::MINUTE_W-1:0] cfg_start [PROGRAMS];
    logic                         pump_on = 1'b0;
    logic                         fill_on = 1'b0;
    logic [ipc_pkg::COUNT_W-1:0]  wet_halves = '0;

    ipc_pkg::result_t             outcome_due [$];
    step_t                        script [$];
    int                           send_idle_pct = 0;
    int                           recv_idle_pct = 0;
    int                           n_passes = 0;
    int                           n_checked = 0;
    int                           n_errors = 0;

    irrigation_pump_controller #(.NUM_PROGRAMS(PROGRAMS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample_bus),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_bus),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    function automatic void load_register(input logic [ipc_pkg::REG_IDX_W-1:0] idx,
                                          input logic [ipc_pkg::DATA_W-1:0] value);
        case (idx)
            ipc_pkg::REG_SETPOINT:  cfg_setpoint = value[6:0];
            ipc_pkg::REG_MODE:      cfg_mode = value[0];
            ipc_pkg::REG_OFF_DELAY: cfg_off_delay = value[14:0];
            ipc_pkg::REG_START_ONE: cfg_start[0] = value[ipc_pkg::MINUTE_W-1:0];
            REG_START_TWO:          cfg_start[1] = value[ipc_pkg::MINUTE_W-1:0];
            REG_START_THREE:        cfg_start[2] = value[ipc_pkg::MINUTE_W-1:0];
            default:                ;
        endcase
    endfunction

    function automatic ipc_pkg::result_t run_control_pass(input ipc_pkg::sample_t s);
        ipc_pkg::result_t r;
        int               pct;
        logic             dry;
        logic             wet;
        pct = int'(s.moisture_raw) * 100 / 1023;
        dry = pct < int'(cfg_setpoint);
        wet = cfg_mode ? (pct > int'(cfg_setpoint)) : (pct >= int'(cfg_setpoint));
        if (s.half_tick && pump_on && wet && wet_halves != ipc_pkg::COUNT_MAX)
            wet_halves = wet_halves + 1'b1;
        for (int k = 0; k < PROGRAMS; k++)
        begin
            if (int'(s.clock_hour) == int'(cfg_start[k]) / 60 &&
                int'(s.clock_minute) == int'(cfg_start[k]) % 60 &&
                s.clock_second == 6'd0 && dry)
                pump_on = 1'b1;
        end
        if (cfg_mode && dry)
            pump_on = 1'b1;
        else if (cfg_mode && (wet_halves >> 1) >= cfg_off_delay)
            pump_on = 1'b0;
        if (s.clock_hour == 5'd0 && s.clock_minute == 6'd0 && s.clock_second == 6'd0)
            pump_on = 1'b0;
        if (s.tank_high_raw < ipc_pkg::LEVEL_LOW)
            fill_on = 1'b0;
        if (s.tank_low_raw < ipc_pkg::LEVEL_LOW && s.tank_high_raw > ipc_pkg::LEVEL_HIGH)
            fill_on = 1'b1;
        if (pump_on && (wet_halves >> 1) >= cfg_off_delay)
        begin
            pump_on = 1'b0;
            wet_halves = '0;
        end
        r.pump_drive = pump_on;
        r.fill_drive = fill_on;
        r.dry_lamp = dry;
        r.moisture_percent = 7'(pct);
        return r;
    endfunction

    function automatic logic [9:0] draw_tank(input int low_weight);
        int r;
        r = $urandom_range(99);
        if (r < low_weight)
            return 10'($urandom_range(9));
        else if (r < low_weight + 30)
            return 10'($urandom_range(1023, 501));
        else if (r < low_weight + 50)
            return 10'($urandom_range(500, 10));
        return 10'($urandom_range(1023));
    endfunction

    function automatic ipc_pkg::sample_t draw_pass();
        ipc_pkg::sample_t s;
        int               r;
        int               k;
        int               level;
        s.half_tick = ($urandom_range(99) < 60);
        r = $urandom_range(99);
        if (r < 40)
        begin
            k = $urandom_range(PROGRAMS - 1);
            s.clock_hour = 5'(cfg_start[k] / 60);
            s.clock_minute = 6'(cfg_start[k] % 60);
        end
        else if (r < 46)
        begin
            s.clock_hour = 5'd0;
            s.clock_minute = 6'd0;
        end
        else if (r < 56)
        begin
            s.clock_hour = 5'($urandom_range(31));
            s.clock_minute = 6'($urandom_range(63));
        end
        else
        begin
            s.clock_hour = 5'($urandom_range(23));
            s.clock_minute = 6'($urandom_range(59));
        end
        r = $urandom_range(99);
        if (r < 50)
            s.clock_second = 6'd0;
        else if (r < 60)
            s.clock_second = 6'($urandom_range(63));
        else
            s.clock_second = 6'($urandom_range(59));
        if ($urandom_range(1) == 1)
        begin
            level = int'(cfg_setpoint) * 1023 / 100 + int'($urandom_range(60)) - 30;
            if (level < 0)
                level = 0;
            if (level > 1023)
                level = 1023;
            s.moisture_raw = 10'(level);
        end
        else
            s.moisture_raw = 10'($urandom_range(1023));
        s.tank_high_raw = draw_tank(20);
        s.tank_low_raw = draw_tank(45);
        return s;
    endfunction

    function automatic step_t pass_row(input logic tick, input int hh, input int mm,
                                       input int ss, input int raw, input int hi,
                                       input int lo);
        step_t r;
        r = '0;
        r.item = '{tick, 5'(hh), 6'(mm), 6'(ss), 10'(raw), 10'(hi), 10'(lo)};
        return r;
    endfunction

    function automatic step_t known_row(input logic tick, input int hh, input int mm,
                                        input int ss, input int raw, input int hi,
                                        input int lo, input logic pump, input logic fill,
                                        input logic dry, input int pct);
        step_t r;
        r = pass_row(tick, hh, mm, ss, raw, hi, lo);
        r.typed = 1'b1;
        r.outcome = '{pump, fill, dry, 7'(pct)};
        return r;
    endfunction

    function automatic step_t write_row(input logic [ipc_pkg::REG_IDX_W-1:0] idx,
                                        input logic [ipc_pkg::DATA_W-1:0] value);
        step_t r;
        r = '0;
        r.is_write = 1'b1;
        r.reg_idx = idx;
        r.reg_value = value;
        return r;
    endfunction

    task automatic push_sample(input ipc_pkg::sample_t s, input logic typed,
                               input ipc_pkg::result_t known);
        ipc_pkg::result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_bus <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        predicted = run_control_pass(s);
        outcome_due.push_back(typed ? known : predicted);
        n_passes++;
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        while (outcome_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [ipc_pkg::REG_IDX_W-1:0] idx,
                             input logic [ipc_pkg::DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        load_register(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_settings(input logic [ipc_pkg::DATA_W-1:0] setpoint,
                                    input logic [ipc_pkg::DATA_W-1:0] mode,
                                    input logic [ipc_pkg::DATA_W-1:0] delay,
                                    input logic [ipc_pkg::DATA_W-1:0] first,
                                    input logic [ipc_pkg::DATA_W-1:0] second,
                                    input logic [ipc_pkg::DATA_W-1:0] third);
        write_reg(ipc_pkg::REG_SETPOINT, setpoint);
        write_reg(ipc_pkg::REG_MODE, mode);
        write_reg(ipc_pkg::REG_OFF_DELAY, delay);
        write_reg(ipc_pkg::REG_START_ONE, first);
        write_reg(REG_START_TWO, second);
        write_reg(REG_START_THREE, third);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (outcome_due.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result pump=%0d fill=%0d dry=%0d pct=%0d",
                         $time, result_bus.pump_drive, result_bus.fill_drive,
                         result_bus.dry_lamp, result_bus.moisture_percent);
            end
            else
            begin
                if (result_bus.pump_drive !== outcome_due[0].pump_drive ||
                    result_bus.fill_drive !== outcome_due[0].fill_drive ||
                    result_bus.dry_lamp !== outcome_due[0].dry_lamp ||
                    result_bus.moisture_percent !== outcome_due[0].moisture_percent)
                begin
                    n_errors++;
                    $display("%0t: mismatch expected pump=%0d fill=%0d dry=%0d pct=%0d, %s",
                             $time, outcome_due[0].pump_drive, outcome_due[0].fill_drive,
                             outcome_due[0].dry_lamp, outcome_due[0].moisture_percent,
                             $sformatf("got pump=%0d fill=%0d dry=%0d pct=%0d",
                                       result_bus.pump_drive, result_bus.fill_drive,
                                       result_bus.dry_lamp,
                                       result_bus.moisture_percent));
                end
                void'(outcome_due.pop_front());
                n_checked++;
            end
        end
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        for (int k = 0; k < PROGRAMS; k++)
            cfg_start[k] = '0;
        script = '{
            known_row(0, 12, 0, 30, 0, 100, 100, 0, 0, 0, 0),
            known_row(1, 23, 59, 59, 1023, 100, 100, 0, 0, 0, 100),
            known_row(0, 0, 0, 0, 1022, 9, 0, 0, 0, 0, 99),
            known_row(1, 31, 63, 63, 11, 501, 9, 0, 1, 0, 1),
            known_row(0, 5, 5, 5, 512, 500, 9, 0, 1, 0, 50),
            known_row(0, 6, 6, 6, 1000, 1023, 1023, 0, 1, 0, 97),
            known_row(1, 7, 7, 7, 1023, 0, 0, 0, 0, 0, 100),
            known_row(0, 8, 8, 8, 10, 1023, 0, 0, 1, 0, 0),
            known_row(1, 9, 9, 9, 341, 10, 10, 0, 1, 0, 33),
            known_row(0, 10, 10, 10, 682, 9, 1023, 0, 0, 0, 66),
            write_row(ipc_pkg::REG_SETPOINT, 32'hFFFF_FFB2),
            write_row(ipc_pkg::REG_START_ONE, 32'd510),
            pass_row(0, 8, 30, 0, 0, 100, 100),
            write_row(ipc_pkg::REG_OFF_DELAY, 32'd2),
            pass_row(0, 8, 30, 0, 0, 100, 100),
            pass_row(1, 8, 30, 1, 1023, 100, 100),
            pass_row(1, 8, 30, 2, 1023, 100, 100),
            pass_row(1, 8, 30, 3, 1023, 100, 100),
            pass_row(1, 8, 30, 4, 1023, 100, 100),
            pass_row(0, 8, 30, 0, 0, 100, 100),
            pass_row(1, 0, 0, 0, 0, 100, 100),
            write_row(ipc_pkg::REG_MODE, 32'd1),
            write_row(ipc_pkg::REG_SETPOINT, 32'd100),
            pass_row(0, 12, 0, 7, 500, 100, 100),
            pass_row(1, 12, 0, 8, 1023, 100, 100),
            write_row(ipc_pkg::REG_SETPOINT, 32'd99),
            pass_row(1, 12, 0, 9, 1023, 100, 100),
            write_row(REG_SPARE_SIX, 32'hFFFF_FFFF),
            write_row(REG_SPARE_SEVEN, 32'h1234_5678),
            write_row(REG_START_TWO, 32'd1439),
            write_row(REG_START_THREE, 32'hFFFF_FFFF),
            write_row(ipc_pkg::REG_MODE, 32'd0),
            pass_row(0, 23, 59, 0, 0, 100, 100),
            pass_row(1, 23, 59, 1, 1023, 100, 100)
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 30;
        recv_idle_pct = 74;

        foreach (script[i])
        begin
            if (script[i].is_write)
            begin
                drain();
                write_reg(script[i].reg_idx, script[i].reg_value);
            end
            else
                push_sample(script[i].item, script[i].typed, script[i].outcome);
        end

        for (int ph = 0; ph < SETTINGS_COUNT; ph++)
        begin
            case (ph / 2)
                0:
                begin
                    send_idle_pct = 30;
                    recv_idle_pct = 74;
                end
                1:
                begin
                    send_idle_pct = 74;
                    recv_idle_pct = 30;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            drain();
            case (ph)
                0: program_settings(32'hFFFF_FFB2, 32'd0, 32'd6, 32'd0, 32'd1439, 32'd600);
                1: program_settings(32'd100, 32'd1, 32'd3, 32'hFFFF_FFFF, 32'd61, 32'd1200);
                2: program_settings(32'd0, 32'd1, 32'd0, 32'd720, 32'd1500, 32'd5);
                3: program_settings(32'd55, 32'hFFFF_FFFE, 32'd32767, 32'd100, 32'd200,
                                    32'd300);
                4: program_settings($urandom_range(127), $urandom_range(1), $urandom_range(12),
                                    $urandom_range(1439), $urandom_range(1439),
                                    $urandom_range(1439));
                default: program_settings(32'd127, 32'd0, 32'd1, 32'd1439, 32'd0, 32'd1500);
            endcase
            repeat (PASSES_PER_SETTING)
                push_sample(draw_pass(), 1'b0, '0);
        end

        drain();
        repeat (4) @(posedge clk);
        $display("Ran %0d control passes over %0d register settings plus directed rows;",
                 n_passes, SETTINGS_COUNT);
        $display("checked %0d results, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0 && outcome_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- irrigation_pump_controller.f -----
+incdir+src
src/ipc_pkg.sv
src/ipc_cfg.sv
src/irrigation_pump_controller.sv
src/ipc_checker.sv
bench/tb.sv
